/* rtl/core/msi_vector_its_command_generator_macros.svh */
// assertion macros for the msi vector its command generator
`ifndef MSI_VECTOR_ITS_COMMAND_GENERATOR_MACROS_SVH
`define MSI_VECTOR_ITS_COMMAND_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define MIC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MIC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MIC_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MIC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/msi_its_pkg.sv */
// shared types and constants of the its command generator
package msi_its_pkg;

  // request codes
  localparam logic [1:0] REQ_MAP   = 2'd0;
  localparam logic [1:0] REQ_UNMAP = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;

  // its opcodes
  localparam logic [7:0] OP_MOVI    = 8'h01;
  localparam logic [7:0] OP_SYNC    = 8'h05;
  localparam logic [7:0] OP_MAPTI   = 8'h0A;
  localparam logic [7:0] OP_INV     = 8'h0C;
  localparam logic [7:0] OP_DISCARD = 8'h0F;

  localparam logic [31:0] LPI_FIRST_ID = 32'd8192;

  // depth of the queue between front and back, power of two
  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_MAP,
    CMD_MOVE,
    CMD_UNMAP
  } cmd_kind_t;

  // one classified request, ready to expand into three commands
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  idx;
    logic [15:0] dev;
    logic [2:0]  coll;
    logic [31:0] base;
  } cmd_desc_t;

endpackage

/* rtl/core/msi_vector_its_command_generator.sv */
// top level of the msi vector to its command generator
// Turns vector routing requests into ITS commands of four 64-bit words.
// A map request on an unmapped vector emits MAPTI, INV and SYNC (SYNC to the
// target cpu); a map to a different cpu emits MOVI, INV and SYNC (SYNC to the
// old cpu); an unmap of a mapped vector emits DISCARD, INV and SYNC (SYNC to
// its current cpu) and leaves the route entry in place. Load requests write a
// redistributor base and emit nothing; map to the current cpu, unmap of an
// unmapped vector, request type 3, a map with an out-of-range vector or cpu
// and an unmap with an out-of-range vector emit nothing. last_command marks
// the SYNC word that closes each run. Both sides are queues: push/full for
// requests, empty/pop for command words. The front does a registered route
// table lookup, then classify and update; full is high from each push until
// that request is done, including any wait while the queue ahead of the back
// is full for a request that emits commands. The back emits one command per
// cycle while its output word is popped, and sustained throughput is limited
// by the back. A two-entry queue between front and back lets the front keep
// taking requests while commands drain. The route table is a memory with
// per-entry mapped bits cleared by reset, so there is no clearing pass and
// requests are taken from the first cycle after reset.
module msi_vector_its_command_generator #(
  parameter int NUM_VECTORS = 256,
  parameter int NUM_CPUS    = 8
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  lpi_index,
  input  logic [7:0]  pci_bus,
  input  logic [4:0]  pci_slot,
  input  logic [2:0]  pci_func,
  input  logic [2:0]  dest_cpu,
  input  logic [31:0] base_value,
  // command word side
  output logic        empty,
  input  logic        pop,
  output logic [63:0] word_zero,
  output logic [63:0] word_one,
  output logic [63:0] word_two,
  output logic [63:0] word_three,
  output logic        last_command
);

  // classified request flowing front to back
  msi_its_pkg::cmd_desc_t fq_data;
  msi_its_pkg::cmd_desc_t bq_data;
  logic fq_wr;
  logic fq_full;
  logic bq_rd;
  logic bq_ne;

  // front: lookup, classify, route and base table updates
  msi_its_front #(
    .NUM_VECTORS (NUM_VECTORS),
    .NUM_CPUS    (NUM_CPUS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req_type   (req_type),
    .lpi_index  (lpi_index),
    .pci_bus    (pci_bus),
    .pci_slot   (pci_slot),
    .pci_func   (pci_func),
    .dest_cpu   (dest_cpu),
    .base_value (base_value),
    .q_wr       (fq_wr),
    .q_data     (fq_data),
    .q_full     (fq_full)
  );

  // decoupling queue, base value already resolved so later loads cannot race
  msi_its_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (fq_wr),
    .wr_data (fq_data),
    .q_full  (fq_full),
    .rd_en   (bq_rd),
    .rd_data (bq_data),
    .q_ne    (bq_ne)
  );

  // back: three commands per entry through a registered output word
  msi_its_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_ne         (bq_ne),
    .q_data       (bq_data),
    .q_rd         (bq_rd),
    .empty        (empty),
    .pop          (pop),
    .word_zero    (word_zero),
    .word_one     (word_one),
    .word_two     (word_two),
    .word_three   (word_three),
    .last_command (last_command)
  );

endmodule

/* rtl/core/msi_its_queue.sv */
// small queue of classified requests between front and back
module msi_its_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  msi_its_pkg::cmd_desc_t wr_data,
  output logic                   q_full,
  input  logic                   rd_en,
  output msi_its_pkg::cmd_desc_t rd_data,
  output logic                   q_ne
);

  localparam int QA_W = (msi_its_pkg::Q_DEPTH > 1) ? $clog2(msi_its_pkg::Q_DEPTH) : 1;

  msi_its_pkg::cmd_desc_t mem [msi_its_pkg::Q_DEPTH];
  logic [QA_W-1:0] wr_ptr;
  logic [QA_W-1:0] rd_ptr;
  logic [QA_W:0]   count;

  assign q_full  = (count == (QA_W+1)'(msi_its_pkg::Q_DEPTH));
  assign q_ne    = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/core/msi_its_front.sv */
// request intake, route lookup, classification and table updates
module msi_its_front #(
  parameter int NUM_VECTORS = 256,
  parameter int NUM_CPUS    = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [1:0]             req_type,
  input  logic [7:0]             lpi_index,
  input  logic [7:0]             pci_bus,
  input  logic [4:0]             pci_slot,
  input  logic [2:0]             pci_func,
  input  logic [2:0]             dest_cpu,
  input  logic [31:0]            base_value,
  output logic                   q_wr,
  output msi_its_pkg::cmd_desc_t q_data,
  input  logic                   q_full
);

  // only the first 256 vectors and 8 cpus are reachable by the fields
  localparam int VEC_N = (NUM_VECTORS > 256) ? 256 : NUM_VECTORS;
  localparam int CPU_N = (NUM_CPUS > 8) ? 8 : NUM_CPUS;
  localparam int RA_W  = (VEC_N > 1) ? $clog2(VEC_N) : 1;
  localparam int BA_W  = (CPU_N > 1) ? $clog2(CPU_N) : 1;
  localparam logic [8:0] VEC_LIM = 9'(VEC_N);
  localparam logic [3:0] CPU_LIM = 4'(CPU_N);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  state_t state;

  logic [1:0]  r_type;
  logic [7:0]  r_idx;
  logic [15:0] r_dev;
  logic [2:0]  r_cpu;
  logic [31:0] r_base;

  // route memory holds the cpu, the valid bit says the vector is mapped
  logic [2:0]       route_mem [VEC_N];
  logic [VEC_N-1:0] mapped;
  logic [2:0]       rd_cpu;
  logic             rd_map;

  logic [31:0] base_tab [CPU_N];

  logic      idx_ok;
  logic      cpu_ok;
  logic      emit;
  logic      route_wr;
  logic      base_wr;
  logic      go;
  logic [2:0] sync_cpu;
  msi_its_pkg::cmd_kind_t kind;

  assign full = (state != S_IDLE);

  always_comb begin
    idx_ok   = ({1'b0, r_idx} < VEC_LIM);
    cpu_ok   = ({1'b0, r_cpu} < CPU_LIM);
    emit     = 1'b0;
    route_wr = 1'b0;
    base_wr  = 1'b0;
    kind     = msi_its_pkg::CMD_MAP;
    sync_cpu = r_cpu;
    unique case (r_type)
      msi_its_pkg::REQ_MAP: begin
        if (idx_ok && cpu_ok) begin
          if (!rd_map) begin
            emit     = 1'b1;
            route_wr = 1'b1;
          end else if (rd_cpu != r_cpu) begin
            emit     = 1'b1;
            route_wr = 1'b1;
            kind     = msi_its_pkg::CMD_MOVE;
            sync_cpu = rd_cpu;
          end
        end
      end
      msi_its_pkg::REQ_UNMAP: begin
        if (idx_ok && rd_map) begin
          emit     = 1'b1;
          kind     = msi_its_pkg::CMD_UNMAP;
          sync_cpu = rd_cpu;
        end
      end
      msi_its_pkg::REQ_LOAD: begin
        base_wr = cpu_ok;
      end
      default: begin
      end
    endcase
    go = !emit || !q_full;
  end

  assign q_wr        = (state == S_EVAL) && emit && go;
  assign q_data.kind = kind;
  assign q_data.idx  = r_idx;
  assign q_data.dev  = r_dev;
  assign q_data.coll = r_cpu;
  assign q_data.base = base_tab[sync_cpu[BA_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mapped <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (go) begin
            state <= S_IDLE;
            if (route_wr) begin
              mapped[r_idx[RA_W-1:0]] <= 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CPU_N; i++) begin
        base_tab[i] <= '0;
      end
    end else if (state == S_EVAL && go && base_wr) begin
      base_tab[r_cpu[BA_W-1:0]] <= r_base;
    end
  end

  // request capture and registered route lookup
  always_ff @(posedge clk) begin
    if (state == S_IDLE && push) begin
      r_type <= req_type;
      r_idx  <= lpi_index;
      r_dev  <= {pci_bus, pci_slot, pci_func};
      r_cpu  <= dest_cpu;
      r_base <= base_value;
      rd_cpu <= route_mem[lpi_index[RA_W-1:0]];
      rd_map <= mapped[lpi_index[RA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EVAL && go && route_wr) begin
      route_mem[r_idx[RA_W-1:0]] <= r_cpu;
    end
  end

endmodule

/* rtl/core/msi_its_back.sv */
// command expansion: one classified request into three its commands
`include "msi_vector_its_command_generator_macros.svh"

module msi_its_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_ne,
  input  msi_its_pkg::cmd_desc_t q_data,
  output logic                   q_rd,
  output logic                   empty,
  input  logic                   pop,
  output logic [63:0]            word_zero,
  output logic [63:0]            word_one,
  output logic [63:0]            word_two,
  output logic [63:0]            word_three,
  output logic                   last_command
);

  typedef enum logic [1:0] {
    ST_FIRST,
    ST_INV,
    ST_SYNC
  } step_t;

  msi_its_pkg::cmd_desc_t cur;
  logic  cur_valid;
  step_t step;
  logic  out_valid;

  logic [63:0] g_w0;
  logic [63:0] g_w1;
  logic [63:0] g_w2;
  logic        g_last;
  logic [31:0] intid;
  logic        adv;
  logic        cur_load;
  logic        last_is_sync;

  assign adv      = cur_valid && (!out_valid || pop);
  assign cur_load = q_ne && (!cur_valid || (adv && step == ST_SYNC));
  assign q_rd     = cur_load;
  assign empty    = !out_valid;
  assign word_three = '0;

  always_comb begin
    intid  = msi_its_pkg::LPI_FIRST_ID + {24'd0, cur.idx};
    g_w0   = {16'd0, cur.dev, 24'd0, msi_its_pkg::OP_INV};
    g_w1   = {56'd0, cur.idx};
    g_w2   = '0;
    g_last = 1'b0;
    case (step)
      ST_FIRST: begin
        case (cur.kind)
          msi_its_pkg::CMD_MAP: begin
            g_w0 = {16'd0, cur.dev, 24'd0, msi_its_pkg::OP_MAPTI};
            g_w1 = {intid, 24'd0, cur.idx};
            g_w2 = {61'd0, cur.coll};
          end
          msi_its_pkg::CMD_MOVE: begin
            g_w0 = {16'd0, cur.dev, 24'd0, msi_its_pkg::OP_MOVI};
            g_w2 = {61'd0, cur.coll};
          end
          default: begin
            g_w0 = {16'd0, cur.dev, 24'd0, msi_its_pkg::OP_DISCARD};
          end
        endcase
      end
      ST_SYNC: begin
        g_w0   = {56'd0, msi_its_pkg::OP_SYNC};
        g_w1   = '0;
        g_w2   = {16'd0, cur.base, 16'd0};
        g_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      step      <= ST_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      // a new entry replaces the finished one in the same cycle
      if (cur_load) begin
        cur_valid <= 1'b1;
        step      <= ST_FIRST;
      end else if (adv) begin
        unique case (step)
          ST_FIRST: step <= ST_INV;
          ST_INV:   step <= ST_SYNC;
          ST_SYNC: begin
            step      <= ST_FIRST;
            cur_valid <= 1'b0;
          end
          default:  step <= ST_FIRST;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur <= q_data;
    end
    if (adv) begin
      word_zero    <= g_w0;
      word_one     <= g_w1;
      word_two     <= g_w2;
      last_command <= g_last;
    end
  end

  assign last_is_sync = (word_zero[7:0] == msi_its_pkg::OP_SYNC);

  `MIC_ASSERT_NOW(a_load_needs_entry, clk, rst, cur_load, q_ne)
  `MIC_ASSERT_NOW(a_last_is_sync, clk, rst, out_valid && last_command, last_is_sync)
  `MIC_ASSERT_NEXT(a_sync_ends_run, clk, rst, adv && step == ST_SYNC && !cur_load, !cur_valid)
  `MIC_ASSERT_NOW(a_step_legal, clk, rst, 1'b1, step == ST_FIRST || step == ST_INV || step == ST_SYNC)

endmodule
